/* hdl/ticketed_ring_queue_macros.svh */
`ifndef TICKETED_RING_QUEUE_MACROS_SVH
`define TICKETED_RING_QUEUE_MACROS_SVH

// same-cycle implication, checked on every clock edge out of reset
`define TKRQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TKRQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/tkrq_pkg.sv */
package tkrq_pkg;

  localparam int unsigned POS_W       = 64;
  localparam int unsigned DATA_W      = 64;
  localparam int unsigned IN_TDATA_W  = 128;
  localparam int unsigned IN_TUSER_W  = 4;
  localparam int unsigned OUT_TDATA_W = 128;
  localparam int unsigned OUT_TUSER_W = 3;

  typedef enum logic [2:0] {
    KIND_PUBLISH = 3'd0,
    KIND_PEEK    = 3'd1,
    KIND_COMMIT  = 3'd2,
    KIND_ACK     = 3'd3,
    KIND_REINIT  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    STAT_PUBLISHED = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_INVALID   = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  typedef struct packed {
    logic             ok;
    status_t          status;
    logic [POS_W-1:0] pout;
    logic             peek;
  } dec_t;

endpackage

/* hdl/tkrq_store.sv */
module tkrq_store
  #(
    parameter int unsigned CAPACITY   = 16,
    parameter int unsigned ENTRY_BITS = 64,
    localparam int unsigned SLOT_W    = $clog2(CAPACITY)
  )
  (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [SLOT_W-1:0]     wr_addr,
    input  logic [ENTRY_BITS-1:0] wr_data,
    input  logic [SLOT_W-1:0]     rd_addr,
    output logic [ENTRY_BITS-1:0] rd_data
  );

  logic [ENTRY_BITS-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/tkrq_ctrl.sv */
module tkrq_ctrl
  import tkrq_pkg::*;
  #(
    parameter int unsigned CAPACITY = 16,
    localparam int unsigned SLOT_W  = $clog2(CAPACITY)
  )
  (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [2:0]        kind,
    input  logic [POS_W-1:0]  position,
    input  logic              ticket_valid,
    output logic              wr_en,
    output logic [SLOT_W-1:0] wr_slot,
    output logic [SLOT_W-1:0] rd_slot,
    output dec_t              dec
  );

  logic [POS_W-1:0] pub_r, pub_nxt;
  logic [POS_W-1:0] com_r, com_nxt;
  logic [POS_W-1:0] pend;
  logic [POS_W-1:0] ack_diff;
  logic             over, full, avail;
  logic             do_pub;

  assign pend     = pub_r - com_r;
  assign ack_diff = com_r - position;
  assign over     = pend > POS_W'(CAPACITY);
  assign full     = pend == POS_W'(CAPACITY);
  assign avail    = !over && (pend != '0);

  assign wr_slot = pub_r[SLOT_W-1:0];
  assign rd_slot = com_r[SLOT_W-1:0];
  assign wr_en   = accept && do_pub;

  always_comb begin
    dec     = '0;
    do_pub  = 1'b0;
    pub_nxt = pub_r;
    com_nxt = com_r;
    unique case (kind_t'(kind))
      KIND_PUBLISH: begin
        if (over) begin
          dec.status = STAT_INVALID;
        end else if (full) begin
          dec.status = STAT_FULL;
        end else begin
          do_pub   = 1'b1;
          pub_nxt  = pub_r + 1'b1;
          dec.ok   = 1'b1;
          dec.pout = pub_r + 1'b1;
        end
      end
      KIND_PEEK: begin
        if (avail) begin
          dec.ok   = 1'b1;
          dec.peek = 1'b1;
          dec.pout = com_r;
        end
      end
      KIND_COMMIT: begin
        if (avail && (position == com_r)) begin
          com_nxt = com_r + 1'b1;
          dec.ok  = 1'b1;
        end
      end
      KIND_ACK: begin
        dec.ok = ticket_valid && !ack_diff[POS_W-1];
      end
      KIND_REINIT: begin
        pub_nxt = position;
        com_nxt = position;
        dec.ok  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pub_r <= '0;
      com_r <= '0;
    end else if (accept) begin
      pub_r <= pub_nxt;
      com_r <= com_nxt;
    end
  end

endmodule

/* hdl/ticketed_ring_queue.sv */
// Single-producer single-consumer ring queue with free-running 64-bit publish
// and commit positions; each transaction on the input carries one operation
// (publish, peek, commit, acknowledge query, reinit) and yields exactly one
// result transaction. Each operation runs as follows: the accept cycle updates
// the positions and writes or addresses the entry memory, and the next cycle
// picks up the registered memory read and loads the output register. A new
// transaction is taken once the previous result has left or is leaving the
// output register. Entry slot = position mod CAPACITY (a power of two).
module ticketed_ring_queue
  import tkrq_pkg::*;
  #(
    parameter int unsigned CAPACITY   = 16,
    parameter int unsigned ENTRY_BITS = 64
  )
  (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_tvalid,
    output logic                   in_tready,
    input  logic [IN_TDATA_W-1:0]  in_tdata,   // entry_data[63:0], position[127:64]
    input  logic [IN_TUSER_W-1:0]  in_tuser,   // kind[2:0], ticket_valid[3]
    output logic                   out_tvalid,
    input  logic                   out_tready,
    output logic [OUT_TDATA_W-1:0] out_tdata,  // entry_out[63:0], position_out[127:64]
    output logic [OUT_TUSER_W-1:0] out_tuser   // ok[0], publish_status[2:1]
  );

  localparam int unsigned SLOT_W = $clog2(CAPACITY);

  state_t                state_r, state_nxt;
  logic                  accept;
  logic                  load;
  dec_t                  dec, dec_r;
  logic                  wr_en;
  logic [SLOT_W-1:0]     wr_slot, rd_slot;
  logic [ENTRY_BITS-1:0] rd_data;
  logic                  out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [OUT_TUSER_W-1:0] out_tuser_r;
  logic [DATA_W-1:0]     entry_ext;

  assign in_tready = (state_r == S_IDLE) && (!out_tvalid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  tkrq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .kind         (in_tuser[2:0]),
    .position     (in_tdata[127:64]),
    .ticket_valid (in_tuser[3]),
    .wr_en        (wr_en),
    .wr_slot      (wr_slot),
    .rd_slot      (rd_slot),
    .dec          (dec)
  );

  tkrq_store #(.CAPACITY(CAPACITY), .ENTRY_BITS(ENTRY_BITS)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_slot),
    .wr_data (in_tdata[ENTRY_BITS-1:0]),
    .rd_addr (rd_slot),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    load      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        load      = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dec_r <= dec;
    end
  end

  assign entry_ext = dec_r.peek ? DATA_W'(rd_data) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tdata_r <= {dec_r.pout, entry_ext};
      out_tuser_r <= {dec_r.status, dec_r.ok};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

/* hdl/tkrq_checker.sv */
`include "ticketed_ring_queue_macros.svh"

module tkrq_checker
  import tkrq_pkg::*;
  (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_tvalid,
    input logic                   in_tready,
    input logic                   out_tvalid,
    input logic                   out_tready,
    input logic [OUT_TDATA_W-1:0] out_tdata,
    input logic [OUT_TUSER_W-1:0] out_tuser
  );

  `TKRQ_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `TKRQ_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "second transaction taken early")
  `TKRQ_ASSERT_NOW(a_status_code, out_tvalid, out_tuser[2:1] != 2'd3, "unknown publish status")
  `TKRQ_ASSERT_NOW(a_status_not_ok, out_tvalid && (out_tuser[2:1] != 2'd0), !out_tuser[0], "failed publish reported ok")
  `TKRQ_ASSERT_NOW(a_entry_needs_ok, out_tvalid && (out_tdata[63:0] != 64'd0), out_tuser[0], "entry shown without ok")

endmodule

bind ticketed_ring_queue tkrq_checker u_tkrq_checker (.*);

/* tb/ticketed_ring_queue_checker.sv */
module ticketed_ring_queue_checker
  import tkrq_pkg::*;
  #(
    parameter int unsigned CAPACITY   = 16,
    parameter int unsigned ENTRY_BITS = 64
  )
  (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_tvalid,
    input  logic                   in_tready,
    input  logic [IN_TDATA_W-1:0]  in_tdata,   // entry_data[63:0], position[127:64]
    input  logic [IN_TUSER_W-1:0]  in_tuser,   // kind[2:0], ticket_valid[3]
    input  logic                   out_tvalid,
    input  logic                   out_tready,
    input  logic [OUT_TDATA_W-1:0] out_tdata,  // entry_out[63:0], position_out[127:64]
    input  logic [OUT_TUSER_W-1:0] out_tuser,  // ok[0], publish_status[2:1]
    output int unsigned            mismatch_count,
    output int unsigned            answers_owed
  );

  localparam logic [DATA_W-1:0] ENTRY_MASK = {DATA_W{1'b1}} >> (DATA_W - ENTRY_BITS);

  typedef struct packed {
    logic              ok;
    status_t           status;
    logic [DATA_W-1:0] entry;
    logic [POS_W-1:0]  pos;
  } answer_t;

  logic [POS_W-1:0]  publish_pos;
  logic [POS_W-1:0]  commit_pos;
  logic [DATA_W-1:0] slots [CAPACITY];
  answer_t           answers_due [$];

  function automatic answer_t apply_queue_op(input logic [2:0] k,
                                             input logic [DATA_W-1:0] d,
                                             input logic [POS_W-1:0] p,
                                             input logic tv);
    answer_t          a;
    logic [POS_W-1:0] held;
    logic [POS_W-1:0] lag;
    a = '0;
    held = publish_pos - commit_pos;
    case (k)
      KIND_PUBLISH: begin
        if (held > CAPACITY) begin
          a.status = STAT_INVALID;
        end else if (held == CAPACITY) begin
          a.status = STAT_FULL;
        end else begin
          slots[publish_pos % CAPACITY] = d & ENTRY_MASK;
          publish_pos = publish_pos + 1;
          a.ok  = 1'b1;
          a.pos = publish_pos;
        end
      end
      KIND_PEEK: begin
        if (held != 0 && held <= CAPACITY) begin
          a.ok    = 1'b1;
          a.entry = slots[commit_pos % CAPACITY] & ENTRY_MASK;
          a.pos   = commit_pos;
        end
      end
      KIND_COMMIT: begin
        if (p == commit_pos && held != 0 && held <= CAPACITY) begin
          commit_pos = commit_pos + 1;
          a.ok = 1'b1;
        end
      end
      KIND_ACK: begin
        // wrapping half-range compare: passed when the lag is below 2^63
        lag = commit_pos - p;
        a.ok = tv && !lag[POS_W-1];
      end
      KIND_REINIT: begin
        publish_pos = p;
        commit_pos  = p;
        a.ok = 1'b1;
      end
      default: ;
    endcase
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    answer_t got;
    if (!rst_n) begin
      publish_pos = '0;
      commit_pos  = '0;
      answers_due.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        answers_due.push_back(apply_queue_op(in_tuser[2:0], in_tdata[DATA_W-1:0],
                                             in_tdata[IN_TDATA_W-1:DATA_W], in_tuser[3]));
      end
      if (out_tvalid && out_tready) begin
        got.ok     = out_tuser[0];
        got.status = status_t'(out_tuser[2:1]);
        got.entry  = out_tdata[DATA_W-1:0];
        got.pos    = out_tdata[OUT_TDATA_W-1:DATA_W];
        if (answers_due.size() == 0) begin
          $error("result transaction with nothing outstanding");
          mismatch_count++;
        end else begin
          want = answers_due.pop_front();
          if (got.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, got.ok);
            mismatch_count++;
          end
          if (got.status !== want.status) begin
            $error("publish_status: expected %0d, got %0d", want.status, got.status);
            mismatch_count++;
          end
          if (got.entry !== want.entry) begin
            $error("entry_out: expected %h, got %h", want.entry, got.entry);
            mismatch_count++;
          end
          if (got.pos !== want.pos) begin
            $error("position_out: expected %h, got %h", want.pos, got.pos);
            mismatch_count++;
          end
        end
      end
    end
    answers_owed <= answers_due.size();
  end

endmodule

/* tb/ticketed_ring_queue_tb.sv */
module ticketed_ring_queue_tb
  import tkrq_pkg::*;
  ();

  localparam int unsigned      DEPTH       = 16;
  localparam int unsigned      WORD_BITS   = 64;
  localparam int unsigned      RANDOM_OPS  = 1100;
  localparam int unsigned      STALL_LIMIT = 4000;
  localparam logic [POS_W-1:0] HALF        = 64'h8000_0000_0000_0000;
  localparam logic [2:0]       KIND_SPARE  = 3'd7;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  int unsigned      mismatch_count;
  int unsigned      answers_owed;
  int unsigned      tx_idle;
  int unsigned      rx_idle;
  int unsigned      issued;
  int unsigned      quiet;
  logic [POS_W-1:0] head_pos;
  int unsigned      fill;

  ticketed_ring_queue #(
    .CAPACITY   (DEPTH),
    .ENTRY_BITS (WORD_BITS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  ticketed_ring_queue_checker #(
    .CAPACITY   (DEPTH),
    .ENTRY_BITS (WORD_BITS)
  ) u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .mismatch_count (mismatch_count),
    .answers_owed   (answers_owed)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("** ticketed_ring_queue: FAILED **");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // head_pos tracks the commit position and fill the occupancy so that commits can be aimed
  task automatic send_op(input logic [2:0] k, input logic [DATA_W-1:0] d,
                         input logic [POS_W-1:0] p, input logic tv);
    while ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {p, d};
    in_tuser  <= {tv, k};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    case (k)
      KIND_PUBLISH: begin
        if (fill < DEPTH) fill++;
      end
      KIND_COMMIT: begin
        if (p == head_pos && fill != 0) begin
          head_pos = head_pos + 1;
          fill--;
        end
      end
      KIND_REINIT: begin
        head_pos = p;
        fill = 0;
      end
      default: ;
    endcase
    issued++;
  endtask

  task automatic random_phase(input int unsigned tx, input int unsigned rx,
                              input int unsigned n);
    int unsigned      stop;
    int unsigned      pick;
    int unsigned      reps;
    logic [POS_W-1:0] p;
    tx_idle = tx;
    rx_idle = rx;
    stop = issued + n;
    while (issued < stop) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        reps = $urandom_range(8, 1);
        repeat (reps) begin
          case ($urandom_range(5))
            0, 1: send_op(KIND_PUBLISH, rand64(), rand64(), $urandom_range(1));
            2: send_op(KIND_PEEK, rand64(), rand64(), $urandom_range(1));
            3, 4: send_op(KIND_COMMIT, rand64(), head_pos, $urandom_range(1));
            default: send_op(KIND_COMMIT, rand64(),
                             head_pos ^ (64'd1 << $urandom_range(63)), $urandom_range(1));
          endcase
        end
      end else if (pick < 48) begin
        reps = DEPTH - fill + $urandom_range(2);
        repeat (reps) send_op(KIND_PUBLISH, rand64(), rand64(), $urandom_range(1));
      end else if (pick < 62) begin
        reps = fill + $urandom_range(1);
        repeat (reps) begin
          send_op(KIND_PEEK, rand64(), rand64(), $urandom_range(1));
          send_op(KIND_COMMIT, rand64(), head_pos, $urandom_range(1));
        end
      end else if (pick < 80) begin
        case ($urandom_range(3))
          0: p = head_pos - $urandom_range(20);
          1: p = head_pos + $urandom_range(4, 1);
          2: p = head_pos - HALF + $urandom_range(2) - 64'd1;
          default: p = rand64();
        endcase
        send_op(KIND_ACK, rand64(), p, $urandom_range(3) != 0);
      end else if (pick < 90) begin
        case ($urandom_range(3))
          0: p = '1 - $urandom_range(20);
          1: p = HALF - $urandom_range(20);
          2: p = $urandom_range(20);
          default: p = rand64();
        endcase
        send_op(KIND_REINIT, rand64(), p, $urandom_range(1));
      end else begin
        send_op(3'($urandom_range(7)), rand64(), rand64(), $urandom_range(1));
      end
    end
  endtask

  initial begin
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    tx_idle    = 24;
    rx_idle    = 83;
    issued     = 0;
    head_pos   = '0;
    fill       = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_op(KIND_PEEK, '0, '0, 1'b0);
    send_op(KIND_COMMIT, '0, '0, 1'b1);
    send_op(KIND_REINIT, '1, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
    send_op(KIND_PUBLISH, '1, '1, 1'b1);
    send_op(KIND_PUBLISH, '0, '0, 1'b0);
    repeat (DEPTH - 2) send_op(KIND_PUBLISH, rand64(), rand64(), 1'b0);
    send_op(KIND_PUBLISH, rand64(), rand64(), 1'b1);
    send_op(KIND_PEEK, '0, '0, 1'b0);
    send_op(KIND_COMMIT, '0, head_pos + 1, 1'b0);
    send_op(KIND_COMMIT, '0, head_pos, 1'b0);
    send_op(KIND_ACK, '0, head_pos, 1'b0);
    send_op(KIND_ACK, '0, head_pos, 1'b1);
    send_op(KIND_ACK, '0, head_pos + 1, 1'b1);
    send_op(KIND_ACK, '0, head_pos - HALF, 1'b1);
    send_op(KIND_ACK, '0, head_pos - HALF + 1, 1'b1);
    send_op(KIND_SPARE, '1, '1, 1'b1);

    random_phase(24, 83, RANDOM_OPS / 3);
    random_phase(83, 24, RANDOM_OPS / 3);
    random_phase(0, 0, RANDOM_OPS - 2 * (RANDOM_OPS / 3));

    in_tvalid <= 1'b0;
    while (answers_owed != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("** ticketed_ring_queue: PASSED **");
    end else begin
      $display("** ticketed_ring_queue: FAILED **");
    end
    $finish;
  end

endmodule
